// ===== hdl/mu8_pkg.sv =====
// ----------------------------------------------------------------------------
// mu8_pkg
// Types and constants shared by the modified UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package mu8_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned UNIT_W  = 16;
	localparam int unsigned COUNT_OUT_W = 24;

	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
	localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hc0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
	localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'he0;
	localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1f;
	localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0f;
	localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3f;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_TWO_LAST   = 5'b00010,
		PH_THREE_MID  = 5'b00100,
		PH_THREE_LAST = 5'b01000,
		PH_DROP       = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [UNIT_W-1:0]      code_unit;
		kind_t                  kind;
		logic [COUNT_OUT_W-1:0] char_count;
	} result_t;

endpackage

// ===== hdl/mu8_in_stage.sv =====
// ----------------------------------------------------------------------------
// mu8_in_stage
// Input register: captures one byte per request and holds it for decode.
// ----------------------------------------------------------------------------
module mu8_in_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mu8_pkg::BYTE_W-1:0] in_byte,
	input  logic                       take,
	output logic                       valid_s1,
	output logic [mu8_pkg::BYTE_W-1:0] byte_s1
);
	import mu8_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// ===== hdl/mu8_decode.sv =====
// ----------------------------------------------------------------------------
// mu8_decode
// Per-byte decode: phase, partial code unit and string character count.
// ----------------------------------------------------------------------------
module mu8_decode #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [mu8_pkg::BYTE_W-1:0] byte_s1,
	output logic                       emit,
	output mu8_pkg::result_t           res
);
	import mu8_pkg::*;

	phase_t                   phase_q, phase_d;
	logic [UNIT_W-1:0]        part_q, part_d;
	logic [COUNT_WIDTH-1:0]   cnt_q, cnt_d, cnt_inc;
	logic                     cont, zero;
	logic [UNIT_W-1:0]        merged;

	assign cont    = (byte_s1 & CONT_MASK) == CONT_CODE;
	assign zero    = byte_s1 == '0;
	assign merged  = {part_q[UNIT_W-7:0], byte_s1[5:0]};
	assign cnt_inc = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		phase_d        = phase_q;
		part_d         = part_q;
		cnt_d          = cnt_q;
		emit           = 1'b0;
		res.code_unit  = '0;
		res.kind       = KIND_CHAR;
		res.char_count = COUNT_OUT_W'(cnt_q);
		unique case (phase_q) inside
			PH_TWO_LAST, PH_THREE_MID, PH_THREE_LAST: begin
				if (!cont) begin
					emit     = 1'b1;
					res.kind = KIND_ERROR;
					part_d   = '0;
					if (zero) begin
						phase_d = PH_IDLE;
						cnt_d   = '0;
					end else begin
						phase_d = PH_DROP;
					end
				end else if (phase_q == PH_THREE_MID) begin
					part_d  = merged;
					phase_d = PH_THREE_LAST;
				end else begin
					phase_d        = PH_IDLE;
					emit           = 1'b1;
					res.code_unit  = merged;
					cnt_d          = cnt_inc;
					res.char_count = COUNT_OUT_W'(cnt_inc);
				end
			end
			PH_DROP: begin
				if (zero) begin
					phase_d = PH_IDLE;
					cnt_d   = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (zero) begin
					emit     = 1'b1;
					res.kind = KIND_END;
					cnt_d    = '0;
				end else if ((byte_s1 & ASCII_MASK) == '0) begin
					emit           = 1'b1;
					res.code_unit  = UNIT_W'(byte_s1);
					cnt_d          = cnt_inc;
					res.char_count = COUNT_OUT_W'(cnt_inc);
				end else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE) begin
					part_d  = UNIT_W'(byte_s1 & LEAD2_BITS);
					phase_d = PH_TWO_LAST;
				end else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE) begin
					part_d  = UNIT_W'(byte_s1 & LEAD3_BITS);
					phase_d = PH_THREE_MID;
				end else begin
					emit     = 1'b1;
					res.kind = KIND_ERROR;
					part_d   = '0;
					phase_d  = PH_DROP;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			part_q  <= '0;
			cnt_q   <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			part_q  <= part_d;
			cnt_q   <= cnt_d;
		end
	end

`ifndef SYNTH
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && res.kind == KIND_END |=> cnt_q == '0)
		else $error("count not cleared after end of string");
	a_char_counted: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && res.kind == KIND_CHAR |=> cnt_q != '0)
		else $error("character result left count at zero");
	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DROP |-> !emit)
		else $error("result produced while dropping");
	a_error_zero_unit: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.kind != KIND_CHAR |-> res.code_unit == '0)
		else $error("non-character result carries a code unit");
`endif

endmodule

// ===== hdl/mu8_out_stage.sv =====
// ----------------------------------------------------------------------------
// mu8_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module mu8_out_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            res_valid,
	input  mu8_pkg::result_t                res,
	output logic                            can_take,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mu8_pkg::UNIT_W-1:0]      code_unit,
	output logic [1:0]                      kind,
	output logic [mu8_pkg::COUNT_OUT_W-1:0] char_count
);
	import mu8_pkg::*;

	result_t res_s2;

	assign can_take = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_take) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && res_valid) begin
			res_s2 <= res;
		end
	end

	assign code_unit  = res_s2.code_unit;
	assign kind       = res_s2.kind;
	assign char_count = res_s2.char_count;

endmodule

// ===== hdl/modified_utf8_decoder_core.sv =====
// ----------------------------------------------------------------------------
// modified_utf8_decoder_core
// Java-style modified UTF-8 decoder: bytes in, 16-bit code units out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one byte per request (in_byte).
//   Output channel out_valid/out_ready carries code_unit, kind and
//   char_count. kind 0 is a character, 1 is end of string (zero byte at a
//   character boundary, count then clears), 2 is a malformed sequence, after
//   which bytes up to the next zero byte are dropped, unless the bad byte was zero.
//   Lead and middle bytes of a multi-byte form produce no result.
//   A byte that produces a result passes the input register, then the
//   result register, before it shows on the output.
//   Throughput: one byte per cycle while the receiver does not stall, set
//   by the single decode stage between the input and result registers.
//   Reset (arst_n low) empties both registers, returns to a character
//   boundary and clears the count.
//   When the receiver stalls, the result register holds; the input register
//   still takes a byte that produces no result, and otherwise holds too.
// ----------------------------------------------------------------------------
module modified_utf8_decoder_core #(
	parameter int unsigned COUNT_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mu8_pkg::BYTE_W-1:0]      in_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mu8_pkg::UNIT_W-1:0]      code_unit,
	output logic [1:0]                      kind,
	output logic [mu8_pkg::COUNT_OUT_W-1:0] char_count
);
	import mu8_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;
	logic              emit;
	logic              can_take;
	result_t           res;

	assign adv = valid_s1 && (can_take || !emit);

	mu8_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mu8_decode #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	mu8_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (adv && emit),
		.res        (res),
		.can_take   (can_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_unit  (code_unit),
		.kind       (kind),
		.char_count (char_count)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for modified_utf8_decoder_core.
// A directed table covers the byte classes, overlong forms, bad lead and
// continuation bytes, and dropping up to the terminator. Random strings
// follow: mostly well-formed text, some broken sequences and noise, and one
// long string of a few hundred characters. A behavioral decoder predicts
// every result. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	import mu8_pkg::*;

	localparam int unsigned CNT_W = 24;
	localparam int LIMIT = 200000;

	typedef struct {
		logic [BYTE_W-1:0] val;
		bit                typed;
		result_t           res;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [BYTE_W-1:0]      in_byte = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [UNIT_W-1:0]      code_unit;
	logic [1:0]             kind;
	logic [COUNT_OUT_W-1:0] char_count;

	phase_t             dec_phase = PH_IDLE;
	logic [UNIT_W-1:0]  dec_partial = '0;
	logic [CNT_W-1:0]   dec_count = '0;

	result_t due_units[$];
	row_t    plan[$];
	result_t want;
	bit      steady = 1'b0;
	int      stall_left = 0;
	int      fed = 0;
	int      errors = 0;
	int      cycles = 0;

	modified_utf8_decoder_core #(
		.COUNT_WIDTH(CNT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_unit(code_unit),
		.kind(kind),
		.char_count(char_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("FAIL modified_utf8_decoder_core");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output result_t res);
		logic              is_cont;
		logic              got_char;
		logic              has;
		logic [UNIT_W-1:0] unit;
		is_cont = (b & CONT_MASK) == CONT_CODE;
		got_char = 1'b0;
		has = 1'b0;
		unit = {dec_partial[9:0], b[5:0]};
		res = '0;
		case (dec_phase) inside
			PH_TWO_LAST, PH_THREE_MID, PH_THREE_LAST: begin
				if (!is_cont) begin
					has = 1'b1;
					res.kind = KIND_ERROR;
					res.char_count = COUNT_OUT_W'(dec_count);
					dec_partial = '0;
					if (b == 8'h00) begin
						dec_phase = PH_IDLE;
						dec_count = '0;
					end else begin
						dec_phase = PH_DROP;
					end
				end else if (dec_phase == PH_THREE_MID) begin
					dec_partial = unit;
					dec_phase = PH_THREE_LAST;
				end else begin
					dec_phase = PH_IDLE;
					got_char = 1'b1;
				end
			end
			PH_DROP: begin
				if (b == 8'h00) begin
					dec_phase = PH_IDLE;
					dec_count = '0;
				end
			end
			default: begin
				dec_phase = PH_IDLE;
				if (b == 8'h00) begin
					has = 1'b1;
					res.kind = KIND_END;
					res.char_count = COUNT_OUT_W'(dec_count);
					dec_count = '0;
				end else if ((b & ASCII_MASK) == 8'h00) begin
					unit = UNIT_W'(b);
					got_char = 1'b1;
				end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
					dec_partial = UNIT_W'(b & LEAD2_BITS);
					dec_phase = PH_TWO_LAST;
				end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
					dec_partial = UNIT_W'(b & LEAD3_BITS);
					dec_phase = PH_THREE_MID;
				end else begin
					has = 1'b1;
					res.kind = KIND_ERROR;
					res.char_count = COUNT_OUT_W'(dec_count);
					dec_partial = '0;
					dec_phase = PH_DROP;
				end
			end
		endcase
		if (got_char) begin
			if (dec_count != '1)
				dec_count++;
			has = 1'b1;
			res.code_unit = unit;
			res.kind = KIND_CHAR;
			res.char_count = COUNT_OUT_W'(dec_count);
		end
		return has;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic feed(input logic [BYTE_W-1:0] b);
		result_t res;
		if (dec_phase != PH_DROP)
			fed++;
		send_byte(b);
		if (decode_byte(b, res))
			due_units.push_back(res);
	endtask

	task automatic feed_char();
		case ($urandom_range(0, 2))
			0: feed(BYTE_W'($urandom_range(8'h01, 8'h7f)));
			1: begin
				feed(BYTE_W'($urandom_range(8'hc0, 8'hdf)));
				feed(BYTE_W'($urandom_range(8'h80, 8'hbf)));
			end
			default: begin
				feed(BYTE_W'($urandom_range(8'he0, 8'hef)));
				feed(BYTE_W'($urandom_range(8'h80, 8'hbf)));
				feed(BYTE_W'($urandom_range(8'h80, 8'hbf)));
			end
		endcase
	endtask

	task automatic feed_break();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) begin
			if ($urandom_range(0, 1))
				feed(BYTE_W'($urandom_range(8'h80, 8'hbf)));
			else
				feed(BYTE_W'($urandom_range(8'hf0, 8'hff)));
		end else begin
			if (r == 1) begin
				feed(BYTE_W'($urandom_range(8'hc0, 8'hdf)));
			end else begin
				feed(BYTE_W'($urandom_range(8'he0, 8'hef)));
				if ($urandom_range(0, 1))
					feed(BYTE_W'($urandom_range(8'h80, 8'hbf)));
			end
			case ($urandom_range(0, 2))
				0: feed(8'h00);
				1: feed(BYTE_W'($urandom_range(8'h01, 8'h7f)));
				default: feed(BYTE_W'($urandom_range(8'hc0, 8'hff)));
			endcase
		end
		repeat ($urandom_range(0, 4))
			feed(BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic row(input logic [BYTE_W-1:0] b);
		row_t r;
		r.val = b;
		r.typed = 1'b0;
		r.res = '0;
		plan.push_back(r);
	endtask

	task automatic row_want(input logic [BYTE_W-1:0] b, input logic [UNIT_W-1:0] unit,
			input kind_t k, input int cnt);
		row_t r;
		r.val = b;
		r.typed = 1'b1;
		r.res.code_unit = unit;
		r.res.kind = k;
		r.res.char_count = COUNT_OUT_W'(cnt);
		plan.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_units.size() == 0) begin
				errors++;
				$error("kind: expected no result, got %0d", kind);
			end else begin
				want = due_units.pop_front();
				if (code_unit !== want.code_unit) begin
					errors++;
					$error("code_unit: expected %h, got %h", want.code_unit, code_unit);
				end
				if (kind !== want.kind) begin
					errors++;
					$error("kind: expected %0d, got %0d", want.kind, kind);
				end
				if (char_count !== want.char_count) begin
					errors++;
					$error("char_count: expected %0d, got %0d", want.char_count, char_count);
				end
			end
		end
		if (stall_left == 0 && $urandom_range(0, 3) == 0)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		result_t res;
		bit      has;
		int      n;
		int      brk_at;
		int      strings;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		row_want(8'h00, 16'h0000, KIND_END, 0);
		row_want(8'h7f, 16'h007f, KIND_CHAR, 1);
		row(8'hc0);
		row_want(8'h80, 16'h0000, KIND_CHAR, 2);
		row(8'hdf);
		row_want(8'hbf, 16'h07ff, KIND_CHAR, 3);
		row(8'he0);
		row(8'h80);
		row_want(8'h80, 16'h0000, KIND_CHAR, 4);
		row(8'hef);
		row(8'hbf);
		row_want(8'hbf, 16'hffff, KIND_CHAR, 5);
		row_want(8'h00, 16'h0000, KIND_END, 5);
		row_want(8'h80, 16'h0000, KIND_ERROR, 0);
		row(8'hff);
		row(8'h00);
		row_want(8'hf0, 16'h0000, KIND_ERROR, 0);
		row(8'h00);
		row_want(8'h41, 16'h0041, KIND_CHAR, 1);
		row(8'hc3);
		row_want(8'h41, 16'h0000, KIND_ERROR, 1);
		row(8'h00);
		row(8'he2);
		row_want(8'h00, 16'h0000, KIND_ERROR, 0);
		row(8'he2);
		row(8'h82);
		row_want(8'hc0, 16'h0000, KIND_ERROR, 0);
		row(8'h00);

		foreach (plan[i]) begin
			send_byte(plan[i].val);
			has = decode_byte(plan[i].val, res);
			if (plan[i].typed)
				due_units.push_back(plan[i].res);
			else if (has)
				due_units.push_back(res);
		end

		fed = 0;
		strings = 0;
		while (fed < 600) begin
			if ($urandom_range(0, 7) == 0)
				steady = !steady;
			if (strings == 3) begin
				// one long string
				n = 300;
				brk_at = -1;
			end else begin
				n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 10) : $urandom_range(11, 40);
				brk_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n) : -1;
			end
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 8))
					feed(BYTE_W'($urandom_range(0, 255)));
			end else begin
				for (int i = 0; i <= n; i++) begin
					if (i == brk_at)
						feed_break();
					if (i < n)
						feed_char();
				end
			end
			feed(8'h00);
			strings++;
		end
		in_valid <= 1'b0;

		while (due_units.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && due_units.size() == 0)
			$display("PASS modified_utf8_decoder_core");
		else
			$display("FAIL modified_utf8_decoder_core");
		$finish;
	end

endmodule
